// File: sv/breakpoint_slot_table_assert.svh
// Assertion macros for the breakpoint slot table.
// Used by the modules in this folder; no other dependencies.
`ifndef BREAKPOINT_SLOT_TABLE_ASSERT_SVH
`define BREAKPOINT_SLOT_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BST_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BST_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BST_ASSERT(label, clk, rst, prop, msg)
`define BST_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: sv/bst_pkg.sv
// Shared types and constants for the breakpoint slot table.
// No dependencies.
`default_nettype none
package bst_pkg;
  localparam int Slots = 256;
  localparam int PageBytes = 64;
  localparam int CodeBytes = 16384;
  localparam int SlotW = $clog2(Slots);
  localparam int PageCount = CodeBytes / PageBytes + 1;
  localparam int PageW = $clog2(PageCount);
  localparam int OffW = $clog2(PageBytes);
  localparam int AddrW = $clog2(CodeBytes);

  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_CLEAR_ALL = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE = 3'd1;
  localparam logic [2:0] ST_BAD_ADDR = 3'd2;
  localparam logic [2:0] ST_DUP = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  localparam logic [31:0] OPC_SHORT = 32'h0000_9002;
  localparam logic [31:0] OPC_LONG = 32'h0010_0073;

  // A classified command as it travels from the front end to the back end.
  typedef struct packed {
    logic [1:0] func;
    logic [2:0] status;   // check result; ST_OK means the back end must act
    logic [AddrW-1:0] addr;
    logic [PageW-1:0] page;
    logic short_op;
  } cmd_t;
endpackage
`default_nettype wire

// File: sv/bst_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`default_nettype none
module bst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] wa,
  input  wire logic [Width-1:0]         wd,
  input  wire logic [$clog2(Depth)-1:0] ra,
  output logic      [Width-1:0]         rd
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end
endmodule
`default_nettype wire

// File: sv/bst_front.sv
// Front end: accepts words, checks size and address, pushes commands.
// Depends on bst_pkg and breakpoint_slot_table_assert.svh.
`default_nettype none
module bst_front import bst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  output logic             ready,
  input  wire logic [1:0]  func,
  input  wire logic [31:0] addr,
  input  wire logic [3:0]  bp_size,
  output logic             q_valid,
  input  wire logic        q_ready,
  output cmd_t             q_cmd
);
  localparam int Depth = 2;
  cmd_t q [Depth];
  logic wp, rp;
  logic [1:0] cnt;
  cmd_t c;
  logic [32:0] limit;

  always_comb begin
    limit = 33'(CodeBytes) - 33'(bp_size);
    c.func = func;
    c.addr = addr[AddrW-1:0];
    c.page = PageW'(addr >> OffW);
    c.short_op = (bp_size == 4'd2);
    c.status = ST_OK;
    if (func == OP_SET || func == OP_CLEAR) begin
      if (bp_size != 4'd2 && bp_size != 4'd4) begin
        c.status = ST_BAD_SIZE;
      end else if ({1'b0, addr} >= limit || addr[0]) begin
        c.status = ST_BAD_ADDR;
      end
    end else if (func == OP_LOOKUP && addr[31:AddrW] != '0) begin
      // Stored addresses are narrower than the bus, so a high address never matches.
      c.status = ST_NOT_FOUND;
    end
  end

  assign ready = (cnt != 2'(Depth));
  assign q_valid = (cnt != 2'd0);
  assign q_cmd = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (valid && ready) begin
        q[wp] <= c;
        wp <= ~wp;
      end
      if (q_valid && q_ready) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(valid && ready) - 2'(q_valid && q_ready);
    end
  end

  `include "breakpoint_slot_table_assert.svh"
  `BST_ASSERT(a_cnt_range, clk, rst, cnt <= 2'(Depth), "queue overfilled")
  `BST_ASSERT(a_no_push_full, clk, rst, !(cnt == 2'(Depth)) || !ready, "ready while full")
  `BST_ASSERT(a_cnt_step, clk, rst, (valid && ready && !(q_valid && q_ready)) |=> cnt != 2'd0, "count")
endmodule
`default_nettype wire

// File: sv/bst_back.sv
// Back end: scans the slot table for set, clear and lookup, and updates page counts.
// Depends on bst_pkg, bst_ram and breakpoint_slot_table_assert.svh.
`default_nettype none
module bst_back import bst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  cmd_t             q_cmd,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [7:0]       slot,
  output logic             hit,
  output logic [7:0]       page,
  output logic             first_in_page,
  output logic             page_now_empty,
  output logic [31:0]      patch_word
);
  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_PCRD, S_PCWR, S_WIPE, S_DONE
  } state_t;
  state_t state;
  cmd_t cmd;
  logic [SlotW:0] idx;       // scan index, one extra bit marks the end
  logic [SlotW-1:0] ridx;    // index of the entry now in the RAM read register
  logic rvalid_cmp;
  logic [Slots-1:0] valid_bits;
  logic found, free_found;
  logic [SlotW-1:0] found_idx, free_idx;
  logic [PageW:0] wipe;
  logic wiping;

  logic addr_we;
  logic [AddrW-1:0] addr_rd;
  bst_ram #(.Width(AddrW), .Depth(Slots)) u_addr (
    .clk(clk), .we(addr_we), .wa(free_idx), .wd(cmd.addr),
    .ra(idx[SlotW-1:0]), .rd(addr_rd)
  );

  logic pc_we;
  logic [PageW-1:0] pc_wa;
  logic [5:0] pc_wd, pc_rd;
  bst_ram #(.Width(6), .Depth(1 << PageW)) u_pc (
    .clk(clk), .we(pc_we), .wa(pc_wa), .wd(pc_wd), .ra(cmd.page), .rd(pc_rd)
  );

  logic [5:0] pc_new;
  always_comb begin
    addr_we = (state == S_DECIDE) && cmd.func == OP_SET && !found && free_found;
    pc_new = pc_rd;
    if (cmd.func == OP_SET) begin
      pc_new = pc_rd + 6'd1;
    end else if (pc_rd != 6'd0) begin
      pc_new = pc_rd - 6'd1;
    end
    // The page counts are zeroed by the same sweep after reset and on clear all.
    wiping = (state == S_WIPE) || (state == S_INIT);
    pc_we = (state == S_PCWR) || wiping;
    pc_wa = wiping ? wipe[PageW-1:0] : cmd.page;
    pc_wd = wiping ? 6'd0 : pc_new;
  end

  assign q_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      out_valid <= 1'b0;
      valid_bits <= '0;
      rvalid_cmp <= 1'b0;
      wipe <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          if (wipe == (PageW + 1)'(PageCount - 1)) begin
            state <= S_IDLE;
          end
          wipe <= wipe + 1'b1;
        end
        S_IDLE: begin
          if (q_valid && q_ready) begin
            cmd <= q_cmd;
            idx <= '0;
            found <= 1'b0;
            free_found <= 1'b0;
            rvalid_cmp <= 1'b0;
            wipe <= '0;
            status <= q_cmd.status;
            slot <= '0;
            hit <= 1'b0;
            page <= '0;
            first_in_page <= 1'b0;
            page_now_empty <= 1'b0;
            patch_word <= '0;
            if (q_cmd.func == OP_CLEAR_ALL) begin
              valid_bits <= '0;
              state <= S_WIPE;
            end else if (q_cmd.status != ST_OK) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // The RAM output is registered, so it belongs to the previously issued address.
          if (rvalid_cmp && valid_bits[ridx] && addr_rd == cmd.addr && !found) begin
            found <= 1'b1;
            found_idx <= ridx;
          end
          if (!idx[SlotW]) begin
            if (!valid_bits[idx[SlotW-1:0]] && !free_found) begin
              free_found <= 1'b1;
              free_idx <= idx[SlotW-1:0];
            end
            ridx <= idx[SlotW-1:0];
            rvalid_cmp <= 1'b1;
            idx <= idx + 1'b1;
          end else begin
            rvalid_cmp <= 1'b0;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= S_DONE;
          case (cmd.func)
            OP_SET: begin
              if (found) begin
                status <= ST_DUP;
              end else if (!free_found) begin
                status <= ST_FULL;
              end else begin
                valid_bits[free_idx] <= 1'b1;
                slot <= 8'(free_idx);
                page <= 8'(cmd.page);
                patch_word <= cmd.short_op ? OPC_SHORT : OPC_LONG;
                state <= S_PCRD;
              end
            end
            OP_CLEAR: begin
              if (!found) begin
                status <= ST_NOT_FOUND;
              end else begin
                valid_bits[found_idx] <= 1'b0;
                slot <= 8'(found_idx);
                page <= 8'(cmd.page);
                state <= S_PCRD;
              end
            end
            default: begin
              if (!found) begin
                status <= ST_NOT_FOUND;
              end else begin
                hit <= 1'b1;
                slot <= 8'(found_idx);
              end
            end
          endcase
        end
        S_PCRD: begin
          state <= S_PCWR;
        end
        S_PCWR: begin
          first_in_page <= (cmd.func == OP_SET) && (pc_new == 6'd1);
          page_now_empty <= (cmd.func == OP_CLEAR) && (pc_new == 6'd0);
          state <= S_DONE;
        end
        S_WIPE: begin
          if (wipe == (PageW + 1)'(PageCount - 1)) begin
            state <= S_DONE;
          end
          wipe <= wipe + 1'b1;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `include "breakpoint_slot_table_assert.svh"
  `BST_ASSERT(a_out_idle, clk, rst, out_valid |-> state == S_IDLE, "result shown mid-command")
  `BST_ASSERT(a_hit_ok, clk, rst, (out_valid && hit) |-> status == ST_OK, "hit with error status")
  `BST_ASSERT(a_one_flag, clk, rst, out_valid |-> !(first_in_page && page_now_empty), "both page flags")
endmodule
`default_nettype wire

// File: sv/breakpoint_slot_table.sv
// Breakpoint slot table: set, clear and look up breakpoint addresses.
// The back end reads one slot per cycle over all 256 slots for a set, clear or lookup,
// and a set or clear that changes the table then updates its page count; clear all
// sweeps the 257-entry page count table instead, and a word that fails its checks skips both.
// Throughput: one word at a time in the back end; a two-entry queue decouples input.
// Reset (synchronous, active high) empties the queue, invalidates all slots and then
// zeroes all 257 page counts in a sweep before the back end takes its first word.
`default_nettype none
module breakpoint_slot_table import bst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [31:0] addr,
  input  wire logic [3:0]  bp_size,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [7:0]       slot,
  output logic             hit,
  output logic [7:0]       page,
  output logic             first_in_page,
  output logic             page_now_empty,
  output logic [31:0]      patch_word
);
  logic q_valid, q_ready;
  cmd_t q_cmd;

  bst_front u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .ready(in_ready),
    .func(func), .addr(addr), .bp_size(bp_size),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  bst_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .slot(slot),
    .hit(hit), .page(page), .first_in_page(first_in_page),
    .page_now_empty(page_now_empty), .patch_word(patch_word)
  );
endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for breakpoint_slot_table: a directed table, a fill past full,
// then random set/clear/lookup/clear-all traffic checked against a behavioral table model.
// Depends on bst_pkg and the breakpoint_slot_table RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import bst_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  slot;
    logic        hit;
    logic [7:0]  page;
    logic        first_in_page;
    logic        page_now_empty;
    logic [31:0] patch_word;
  } bp_result_t;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] addr;
    logic [3:0]  bp_size;
    bit          typed;
    logic [2:0]  status;
  } stim_row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] func;
  logic [31:0] addr;
  logic [3:0] bp_size;
  logic [2:0] status;
  logic [7:0] slot, page;
  logic hit, first_in_page, page_now_empty;
  logic [31:0] patch_word;

  breakpoint_slot_table uut (.*);

  // Behavioral copy of the table.
  logic [31:0] bp_addr[Slots];
  bit          bp_used[Slots];
  int unsigned pg_count[PageCount];

  bp_result_t expected_results[$];
  logic [2:0] typed_status[$];
  bit         typed_flag[$];
  bit failed;
  int idle_pct, stall_pct, quiet;
  bit hold_off;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic logic [2:0] arg_status(logic [31:0] a, logic [3:0] sz);
    if (sz != 2 && sz != 4) return ST_BAD_SIZE;
    if ({32'd0, a} >= 64'(CodeBytes) - sz || a[0]) return ST_BAD_ADDR;
    return ST_OK;
  endfunction

  function automatic int find_bp(logic [31:0] a);
    for (int i = 0; i < Slots; i++) if (bp_used[i] && bp_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic bp_result_t apply_command(logic [1:0] f, logic [31:0] a,
                                               logic [3:0] sz);
    bp_result_t r;
    int idx, free_idx;
    int unsigned pg;
    r = '0;
    pg = a / PageBytes;
    case (f)
      OP_SET: begin
        r.status = arg_status(a, sz);
        if (r.status == ST_OK) begin
          free_idx = -1;
          for (int i = Slots - 1; i >= 0; i--) if (!bp_used[i]) free_idx = i;
          if (find_bp(a) >= 0) r.status = ST_DUP;
          else if (free_idx < 0) r.status = ST_FULL;
          else if (pg < PageCount) begin
            bp_addr[free_idx] = a;
            bp_used[free_idx] = 1;
            pg_count[pg]++;
            r.slot = free_idx[7:0];
            r.page = pg[7:0];
            r.first_in_page = (pg_count[pg] == 1);
            r.patch_word = (sz == 2) ? OPC_SHORT : OPC_LONG;
          end
        end
      end
      OP_CLEAR: begin
        r.status = arg_status(a, sz);
        if (r.status == ST_OK) begin
          idx = find_bp(a);
          if (idx < 0) r.status = ST_NOT_FOUND;
          else if (pg < PageCount) begin
            bp_used[idx] = 0;
            if (pg_count[pg] != 0) pg_count[pg]--;
            r.slot = idx[7:0];
            r.page = pg[7:0];
            r.page_now_empty = (pg_count[pg] == 0);
          end
        end
      end
      OP_LOOKUP: begin
        idx = find_bp(a);
        if (idx < 0) r.status = ST_NOT_FOUND;
        else begin
          r.hit = 1;
          r.slot = idx[7:0];
        end
      end
      default: begin
        for (int i = 0; i < Slots; i++) bp_used[i] = 0;
        for (int i = 0; i < PageCount; i++) pg_count[i] = 0;
      end
    endcase
    return r;
  endfunction

  // Drives one word and records its expected result when it is accepted.
  // Valid is dropped only when an idle gap is taken, so it is never driven twice
  // in one time step.
  task automatic send_word(logic [1:0] f, logic [31:0] a, logic [3:0] sz,
                           bit typed, logic [2:0] st);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1;
    func <= f;
    addr <= a;
    bp_size <= sz;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(apply_command(f, a, sz));
    typed_flag.push_back(typed);
    typed_status.push_back(st);
  endtask

  // Receiver side: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 0;
    else out_ready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    bp_result_t e, got;
    if (!rst && out_valid && out_ready) begin
      got = '{status, slot, hit, page, first_in_page, page_now_empty, patch_word};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word %p", $time, got);
        failed = 1;
      end else begin
        e = expected_results.pop_front();
        if (typed_flag.pop_front() && typed_status[0] != got.status) begin
          $display("%0t: status table %0d actual %0d", $time, typed_status[0], got.status);
          failed = 1;
        end
        void'(typed_status.pop_front());
        if (got.status != e.status) begin
          $display("%0t: status exp %0d act %0d", $time, e.status, got.status);
          failed = 1;
        end
        if (got.slot != e.slot) begin
          $display("%0t: slot exp %0d act %0d", $time, e.slot, got.slot);
          failed = 1;
        end
        if (got.hit != e.hit) begin
          $display("%0t: hit exp %0d act %0d", $time, e.hit, got.hit);
          failed = 1;
        end
        if (got.page != e.page) begin
          $display("%0t: page exp %0d act %0d", $time, e.page, got.page);
          failed = 1;
        end
        if (got.first_in_page != e.first_in_page) begin
          $display("%0t: first_in_page exp %0d act %0d", $time, e.first_in_page,
                   got.first_in_page);
          failed = 1;
        end
        if (got.page_now_empty != e.page_now_empty) begin
          $display("%0t: page_now_empty exp %0d act %0d", $time, e.page_now_empty,
                   got.page_now_empty);
          failed = 1;
        end
        if (got.patch_word != e.patch_word) begin
          $display("%0t: patch_word exp %h act %h", $time, e.patch_word, got.patch_word);
          failed = 1;
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no accepted word ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 40000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  stim_row_t directed[] = '{
    '{OP_LOOKUP, 32'h0000_0000, 4'd0, 1, ST_NOT_FOUND},
    '{OP_CLEAR, 32'h0000_0010, 4'd2, 1, ST_NOT_FOUND},
    '{OP_SET, 32'h0000_0000, 4'd0, 1, ST_BAD_SIZE},
    '{OP_SET, 32'h0000_0000, 4'd15, 1, ST_BAD_SIZE},
    '{OP_CLEAR, 32'h0000_0000, 4'd3, 1, ST_BAD_SIZE},
    '{OP_SET, 32'hFFFF_FFFF, 4'd2, 1, ST_BAD_ADDR},
    '{OP_SET, 32'h0000_0011, 4'd4, 1, ST_BAD_ADDR},
    '{OP_SET, 32'h0000_3FFE, 4'd2, 1, ST_BAD_ADDR},
    '{OP_SET, 32'h0000_3FFC, 4'd4, 1, ST_BAD_ADDR},
    '{OP_SET, 32'h0000_3FFC, 4'd2, 0, ST_OK},
    '{OP_SET, 32'h0000_3FFA, 4'd4, 0, ST_OK},
    '{OP_SET, 32'h0000_0000, 4'd2, 0, ST_OK},
    '{OP_SET, 32'h0000_0000, 4'd4, 1, ST_DUP},
    '{OP_SET, 32'h0000_0002, 4'd4, 0, ST_OK},
    '{OP_LOOKUP, 32'h0000_0002, 4'd9, 0, ST_OK},
    '{OP_CLEAR, 32'h0000_0000, 4'd4, 0, ST_OK},
    '{OP_CLEAR, 32'h0000_0002, 4'd2, 0, ST_OK},
    '{OP_SET, 32'h0000_1240, 4'd4, 0, ST_OK},
    '{OP_CLEAR_ALL, 32'hFFFF_FFFF, 4'd15, 1, ST_OK},
    '{OP_LOOKUP, 32'h0000_1240, 4'd0, 1, ST_NOT_FOUND},
    '{OP_CLEAR_ALL, 32'h0000_0000, 4'd0, 1, ST_OK}
  };

  function automatic logic [31:0] rand_addr(int unsigned mode);
    case (mode)
      0: return 32'($urandom_range(8191)) << 1;
      1: return 32'($urandom_range(127)) << 1;
      2: return $urandom;
      default: return 32'h3FF0 + $urandom_range(15);
    endcase
  endfunction

  function automatic logic [3:0] rand_size();
    if ($urandom_range(9) < 8) return $urandom_range(1) ? 4'd4 : 4'd2;
    return 4'($urandom_range(15));
  endfunction

  initial begin
    logic [31:0] placed[$];
    logic [31:0] a;
    int unsigned k, mode;
    rst = 1;
    in_valid = 0;
    func = OP_SET;
    addr = 0;
    bp_size = 0;
    out_ready = 0;
    hold_off = 0;
    failed = 0;
    quiet = 0;
    idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < Slots; i++) begin
      bp_used[i] = 0;
      bp_addr[i] = 0;
    end
    for (int i = 0; i < PageCount; i++) pg_count[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (directed[i])
      send_word(directed[i].func, directed[i].addr, directed[i].bp_size,
                directed[i].typed, directed[i].status);

    // Fill the table past full with a long receiver hold-off at the start.
    hold_off <= 1;
    fork
      begin
        repeat (2000) @(posedge clk);
        hold_off <= 0;
      end
    join_none
    for (int i = 0; i < Slots + 4; i++) begin
      a = 32'(i) << 1;
      send_word(OP_SET, a, 4'd2, 0, ST_OK);
    end
    send_word(OP_SET, 32'h0000_3000, 4'd4, 1, ST_FULL);
    send_word(OP_LOOKUP, 32'd510, 4'd0, 0, ST_OK);
    send_word(OP_CLEAR_ALL, 32'd0, 4'd0, 1, ST_OK);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1 || phase == 3) ? 66 : 0;
      stall_pct = (phase == 2) ? 66 : (phase == 3) ? 7 : 0;
      if (phase == 3) idle_pct = 7;
      for (int n = 0; n < 330; n++) begin
        k = $urandom_range(99);
        mode = $urandom_range(9) < 7 ? $urandom_range(1) : $urandom_range(3);
        if (k < 45) begin
          a = rand_addr(mode);
          send_word(OP_SET, a, rand_size(), 0, ST_OK);
          placed.push_back(a);
        end else if (k < 80) begin
          a = (placed.size() != 0 && $urandom_range(3) != 0)
              ? placed[$urandom_range(placed.size() - 1)] : rand_addr(mode);
          send_word(OP_CLEAR, a, rand_size(), 0, ST_OK);
        end else if (k < 98) begin
          a = (placed.size() != 0 && $urandom_range(1))
              ? placed[$urandom_range(placed.size() - 1)] : rand_addr(mode);
          send_word(OP_LOOKUP, a, 4'($urandom_range(15)), 0, ST_OK);
        end else begin
          send_word(OP_CLEAR_ALL, $urandom, 4'($urandom_range(15)), 0, ST_OK);
          placed.delete();
        end
      end
    end
    in_valid <= 0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (!failed) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
